// ===== hw/rtl/x64e_pkg.sv =====
// Types and constants shared by the x86-64 encoder front end, queue and serializer.
// No dependencies.
`default_nettype none

package x64e_pkg;

  localparam int MaxBytes = 10;

  localparam logic [7:0] RexBase    = 8'h40;
  localparam logic [7:0] OpMovLoad  = 8'h8B;
  localparam logic [7:0] OpMovImm32 = 8'hC7;
  localparam logic [7:0] OpMovImm64 = 8'hB8;
  localparam logic [7:0] SsePrefix  = 8'hF2;
  localparam logic [7:0] Escape0F   = 8'h0F;
  localparam logic [7:0] SibNoIndex = 8'h24;

  typedef enum logic [4:0] {
    OP_MOV_RR   = 5'd0,
    OP_MOV_RI   = 5'd1,
    OP_MOV_RM   = 5'd2,
    OP_MOV_MR   = 5'd3,
    OP_ADD_RR   = 5'd4,
    OP_ADD_RI   = 5'd5,
    OP_SUB_RR   = 5'd6,
    OP_SUB_RI   = 5'd7,
    OP_IMUL_RR  = 5'd8,
    OP_AND_RR   = 5'd9,
    OP_OR_RR    = 5'd10,
    OP_XOR_RR   = 5'd11,
    OP_SHL_RI   = 5'd12,
    OP_SHR_RI   = 5'd13,
    OP_CMP_RR   = 5'd14,
    OP_CMP_RI   = 5'd15,
    OP_TEST_RR  = 5'd16,
    OP_JMP      = 5'd17,
    OP_JCC      = 5'd18,
    OP_CALL     = 5'd19,
    OP_RET      = 5'd20,
    OP_PUSH     = 5'd21,
    OP_POP      = 5'd22,
    OP_MOVSD_LD = 5'd23,
    OP_MOVSD_ST = 5'd24,
    OP_ADDSD    = 5'd25,
    OP_SUBSD    = 5'd26,
    OP_MULSD    = 5'd27,
    OP_DIVSD    = 5'd28
  } opcode_t;

  typedef struct packed {
    logic [4:0]         opcode;
    logic [3:0]         first_reg;
    logic [3:0]         second_reg;
    logic signed [31:0] displacement;
    logic signed [63:0] immediate;
    logic [3:0]         cond_code;
  } req_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } rsp_t;

  // One encoded instruction: bytes in emit order, len in 0..MaxBytes (0: nothing to emit)
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [3:0]               len;
  } enc_t;

endpackage

`default_nettype wire

// ===== hw/rtl/x64e_front.sv =====
// Front end: classifies a request and builds its full byte string combinationally.
// Depends on x64e_pkg.
`default_nettype none

module x64e_front import x64e_pkg::*; (
  input  wire req_t req,
  output enc_t      enc
);

  function automatic enc_t put_b(enc_t e, logic [7:0] b);
    enc_t r;
    r = e;
    if (e.len < 4'(MaxBytes)) begin
      r.bytes[e.len] = b;
      r.len = e.len + 4'd1;
    end
    return r;
  endfunction

  function automatic enc_t put32(enc_t e, logic [31:0] d);
    enc_t r;
    r = put_b(e, d[7:0]);
    r = put_b(r, d[15:8]);
    r = put_b(r, d[23:16]);
    r = put_b(r, d[31:24]);
    return r;
  endfunction

  function automatic logic fits8(logic [31:0] v);
    return (v[31:7] == '0) || (v[31:7] == '1);
  endfunction

  function automatic enc_t put_rex(enc_t e, logic w, logic [3:0] r, logic [3:0] b);
    logic [7:0] rex;
    rex = {4'h4, w, r[3], 1'b0, b[3]};
    return (rex != RexBase) ? put_b(e, rex) : e;
  endfunction

  function automatic enc_t put_modrm(enc_t e, logic [1:0] md, logic [3:0] rg,
                                     logic [3:0] rm);
    return put_b(e, {md, rg[2:0], rm[2:0]});
  endfunction

  function automatic enc_t put_mem(enc_t e, logic [3:0] rg, logic [3:0] base,
                                   logic [31:0] disp);
    enc_t r;
    logic [1:0] md;
    // RBP/R13 base has no mod=0 form, so it falls through to disp8
    if (disp == '0 && base[2:0] != 3'd5) md = 2'd0;
    else if (fits8(disp))                md = 2'd1;
    else                                 md = 2'd2;
    r = put_modrm(e, md, rg, base);
    if (base[2:0] == 3'd4) r = put_b(r, SibNoIndex);
    if (md == 2'd1) r = put_b(r, disp[7:0]);
    else if (md == 2'd2) r = put32(r, disp);
    return r;
  endfunction

  function automatic enc_t alu_rr(enc_t e, logic [7:0] op, logic [3:0] dst,
                                  logic [3:0] src);
    enc_t r;
    r = put_rex(e, 1'b1, src, dst);
    r = put_b(r, op);
    r = put_modrm(r, 2'd3, src, dst);
    return r;
  endfunction

  function automatic enc_t alu_ri(enc_t e, logic [2:0] ext, logic [3:0] dst,
                                  logic [31:0] imm);
    enc_t r;
    r = put_rex(e, 1'b1, 4'd0, dst);
    if (fits8(imm)) begin
      r = put_b(r, 8'h83);
      r = put_modrm(r, 2'd3, {1'b0, ext}, dst);
      r = put_b(r, imm[7:0]);
    end else begin
      r = put_b(r, 8'h81);
      r = put_modrm(r, 2'd3, {1'b0, ext}, dst);
      r = put32(r, imm);
    end
    return r;
  endfunction

  function automatic enc_t shift_ri(enc_t e, logic [2:0] ext, logic [3:0] dst,
                                    logic [7:0] cnt);
    enc_t r;
    r = put_rex(e, 1'b1, 4'd0, dst);
    if (cnt == 8'd1) begin
      r = put_b(r, 8'hD1);
      r = put_modrm(r, 2'd3, {1'b0, ext}, dst);
    end else begin
      r = put_b(r, 8'hC1);
      r = put_modrm(r, 2'd3, {1'b0, ext}, dst);
      r = put_b(r, cnt);
    end
    return r;
  endfunction

  function automatic enc_t sse_pre(enc_t e, logic [3:0] rg, logic [3:0] rm);
    enc_t r;
    r = put_b(e, SsePrefix);
    r = put_rex(r, 1'b0, rg, rm);
    r = put_b(r, Escape0F);
    return r;
  endfunction

  function automatic enc_t sse_rr(enc_t e, logic [7:0] op, logic [3:0] dst,
                                  logic [3:0] src);
    enc_t r;
    r = sse_pre(e, dst, src);
    r = put_b(r, op);
    r = put_modrm(r, 2'd3, dst, src);
    return r;
  endfunction

  logic [3:0]  a;
  logic [3:0]  b;
  logic [31:0] disp;
  logic [63:0] imm;
  logic [31:0] imm32;
  logic        imm_fits32;
  enc_t        e0;

  assign a          = req.first_reg;
  assign b          = req.second_reg;
  assign disp       = req.displacement;
  assign imm        = req.immediate;
  assign imm32      = imm[31:0];
  assign imm_fits32 = (imm[63:31] == '0) || (imm[63:31] == '1);
  assign e0         = '0;

  always_comb begin
    enc = e0;
    unique case (opcode_t'(req.opcode))
      OP_MOV_RR:  enc = alu_rr(e0, 8'h89, a, b);
      OP_MOV_RI: begin
        enc = put_rex(e0, 1'b1, 4'd0, a);
        if (imm_fits32) begin
          enc = put_b(enc, OpMovImm32);
          enc = put_modrm(enc, 2'd3, 4'd0, a);
          enc = put32(enc, imm32);
        end else begin
          enc = put_b(enc, OpMovImm64 + {5'd0, a[2:0]});
          enc = put32(enc, imm32);
          enc = put32(enc, imm[63:32]);
        end
      end
      OP_MOV_RM: begin
        enc = put_rex(e0, 1'b1, a, b);
        enc = put_b(enc, OpMovLoad);
        enc = put_mem(enc, a, b, disp);
      end
      OP_MOV_MR: begin
        enc = put_rex(e0, 1'b1, a, b);
        enc = put_b(enc, 8'h89);
        enc = put_mem(enc, a, b, disp);
      end
      OP_ADD_RR:  enc = alu_rr(e0, 8'h01, a, b);
      OP_ADD_RI:  enc = alu_ri(e0, 3'd0, a, imm32);
      OP_SUB_RR:  enc = alu_rr(e0, 8'h29, a, b);
      OP_SUB_RI:  enc = alu_ri(e0, 3'd5, a, imm32);
      OP_IMUL_RR: begin
        enc = put_rex(e0, 1'b1, a, b);
        enc = put_b(enc, Escape0F);
        enc = put_b(enc, 8'hAF);
        enc = put_modrm(enc, 2'd3, a, b);
      end
      OP_AND_RR:  enc = alu_rr(e0, 8'h21, a, b);
      OP_OR_RR:   enc = alu_rr(e0, 8'h09, a, b);
      OP_XOR_RR:  enc = alu_rr(e0, 8'h31, a, b);
      OP_SHL_RI:  enc = shift_ri(e0, 3'd4, a, imm[7:0]);
      OP_SHR_RI:  enc = shift_ri(e0, 3'd5, a, imm[7:0]);
      OP_CMP_RR:  enc = alu_rr(e0, 8'h39, a, b);
      OP_CMP_RI:  enc = alu_ri(e0, 3'd7, a, imm32);
      OP_TEST_RR: enc = alu_rr(e0, 8'h85, a, b);
      OP_JMP:     enc = put32(put_b(e0, 8'hE9), disp);
      OP_JCC: begin
        enc = put_b(e0, Escape0F);
        enc = put_b(enc, 8'h80 + {4'd0, req.cond_code});
        enc = put32(enc, disp);
      end
      OP_CALL:    enc = put32(put_b(e0, 8'hE8), disp);
      OP_RET:     enc = put_b(e0, 8'hC3);
      OP_PUSH: begin
        enc = a[3] ? put_b(e0, 8'h41) : e0;
        enc = put_b(enc, 8'h50 + {5'd0, a[2:0]});
      end
      OP_POP: begin
        enc = a[3] ? put_b(e0, 8'h41) : e0;
        enc = put_b(enc, 8'h58 + {5'd0, a[2:0]});
      end
      OP_MOVSD_LD: begin
        enc = sse_pre(e0, a, b);
        enc = put_b(enc, 8'h10);
        enc = put_mem(enc, a, b, disp);
      end
      OP_MOVSD_ST: begin
        enc = sse_pre(e0, a, b);
        enc = put_b(enc, 8'h11);
        enc = put_mem(enc, a, b, disp);
      end
      OP_ADDSD:   enc = sse_rr(e0, 8'h58, a, b);
      OP_SUBSD:   enc = sse_rr(e0, 8'h5C, a, b);
      OP_MULSD:   enc = sse_rr(e0, 8'h59, a, b);
      OP_DIVSD:   enc = sse_rr(e0, 8'h5E, a, b);
      default:    enc = e0;  // unused codes emit nothing
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/x64e_queue.sv =====
// Small FIFO of encoded instructions between front end and serializer.
// Depends on x64e_pkg.
`default_nettype none

module x64e_queue import x64e_pkg::*; #(
  parameter int Depth = 2
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  enc_t push_data,
  output logic push_ready,
  input  wire  pop,
  output logic pop_valid,
  output enc_t pop_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  enc_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign push_ready = (cnt_r != CntW'(Depth));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CntW'(1);
    else if (!do_push && do_pop) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/x64e_back.sv =====
// Serializer: holds one encoded instruction and sends it out a byte per beat.
// Depends on x64e_pkg.
`default_nettype none

module x64e_back import x64e_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  q_valid,
  input  enc_t q_data,
  output logic q_pop,
  output logic out_valid,
  input  wire  out_ready,
  output rsp_t out_data
);

  logic       cur_vld_r, cur_vld_nxt;
  enc_t       cur_r, cur_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       is_last;
  logic       beat;

  assign is_last   = (idx_r == 4'(cur_r.len - 4'd1));
  assign beat      = cur_vld_r && out_ready;
  // refill on the final beat so instructions leave with no gap
  assign q_pop     = q_valid && (!cur_vld_r || (beat && is_last));

  assign out_valid          = cur_vld_r;
  assign out_data.code_byte = cur_r.bytes[idx_r];
  assign out_data.last_byte = is_last;

  always_comb begin
    cur_vld_nxt = cur_vld_r;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    if (q_pop) begin
      cur_vld_nxt = 1'b1;
      cur_nxt     = q_data;
      idx_nxt     = '0;
    end else if (beat) begin
      if (is_last) cur_vld_nxt = 1'b0;
      else idx_nxt = idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/x64_instruction_encoder_core.sv =====
// x86-64 instruction encoder, top level: front end, instruction queue, serializer.
// An accepted request goes to the queue, then to the serializer. Throughput: one
// output byte per cycle while out_ready is high; a request of n bytes (1..10)
// holds the output port for all its bytes, so the output port sets the rate.
// Requests are taken every cycle while the queue (QueueDepth entries) has room.
// Reset (rst_n low, synchronous) empties the queue and the serializer.
// Depends on x64e_pkg, x64e_front, x64e_queue, x64e_back.
`default_nettype none

module x64_instruction_encoder_core import x64e_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  wire  out_ready,
  output rsp_t out_data
);

  enc_t enc;
  enc_t q_data;
  logic q_push_ready;
  logic q_valid;
  logic q_pop;

  x64e_front u_front (
    .req (in_data),
    .enc (enc)
  );

  assign in_ready = q_push_ready;

  // requests that encode to nothing are accepted and dropped
  x64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && (enc.len != '0)),
    .push_data  (enc),
    .push_ready (q_push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  x64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/x64e_checker.sv =====
// Port-level checks for the encoder core, bound to the top level.
// Depends on x64e_pkg and x64_instruction_encoder_core.
`default_nettype none

module x64e_checker import x64e_pkg::*; (
  input wire  clk,
  input wire  rst_n,
  input wire  in_ready,
  input wire  out_valid,
  input wire  out_ready,
  input rsp_t out_data
);

  logic [3:0] nbytes_r;

  // bytes sent so far in the current instruction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nbytes_r <= '0;
    end else if (out_valid && out_ready) begin
      nbytes_r <= out_data.last_byte ? 4'd0 : nbytes_r + 4'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_max_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && nbytes_r == 4'(MaxBytes - 1) |-> out_data.last_byte)
    else $error("instruction longer than the maximum length");

  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked while no result pending");

endmodule

bind x64_instruction_encoder_core x64e_checker u_x64e_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
